// ----- src/nsp_pkg.sv -----
// shared types and constants for the next-submask-same-popcount block
// no dependencies

package nsp_pkg;

	localparam int DATA_W = 64;

	typedef logic [DATA_W-1:0] word_t;

endpackage

// ----- src/nsp_if.sv -----
// valid/ready channel interfaces for subset input and successor output
// depends on nsp_pkg

interface nsp_in_if;
	logic               valid;
	logic               ready;
	nsp_pkg::word_t     current_subset;

	modport source (output valid, output current_subset, input ready);
	modport sink (input valid, input current_subset, output ready);
endinterface

interface nsp_out_if;
	logic               valid;
	logic               ready;
	nsp_pkg::word_t     next_subset;
	logic               is_last;

	modport source (output valid, output next_subset, output is_last, input ready);
	modport sink (input valid, input next_subset, input is_last, output ready);
endinterface

// ----- src/next_submask_same_popcount_core.sv -----
// top level: successor of a subset within a configured universe, same member count
// depends on nsp_pkg and the channel interfaces in nsp_if

// Takes subset transactions and returns the successor of each, one result
// per transaction; the sustained rate is one transaction per clock, and the
// whole pipeline holds while a finished result waits at the output. The six
// register stages are: input masking, the free-position candidate mask, the
// lowest candidate bit with keep and low-part masks, member popcount and
// per-byte universe ranks, the rank offsets across bytes, and the low-end
// refill into the output register. The universe register is to be written
// through cfg_we/cfg_wdata only while no transaction is in flight, which the block
// does not enforce. It resets to all ones; only its low SET_WIDTH bits take part.
module next_submask_same_popcount_core #(
	parameter int SET_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  nsp_pkg::word_t     cfg_wdata,
	nsp_in_if.sink             in_ch,
	nsp_out_if.source          out_ch
);
	import nsp_pkg::*;

	localparam int W  = SET_WIDTH;
	localparam int CW = $clog2(W + 1);
	localparam int NG = (W + 7) / 8;
	localparam int UP = NG * 8;

	logic [W-1:0]  universe_q;
	logic [W-1:0]  u;
	logic [UP-1:0] u_pad;
	logic          adv;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [W-1:0]  s_s1;
	logic [W-1:0]  s_s2, cand_s2;
	logic [W-1:0]  hit_s3, m_s3;
	logic          last_s3;
	logic [W-1:0]  hit_s4;
	logic [CW-1:0] k_s4;
	logic [3:0]    lrank_s4 [UP];
	logic [3:0]    gtot_s4 [NG];
	logic          last_s4;
	logic [W-1:0]  hit_s5;
	logic [CW-1:0] k_s5;
	logic [CW-1:0] rank_s5 [W];
	logic          last_s5;
	logic [W-1:0]  res_s6;
	logic          last_s6;

	logic [W-1:0]  low_c, upto_c, cand_c, p_c, keep_c;
	logic [CW-1:0] a_c, k_c;
	logic [3:0]    lrank_c [UP];
	logic [3:0]    gtot_c [NG];
	logic [CW-1:0] rank_c [W];
	logic [CW-1:0] base_c;
	logic [7:0]    grp_c;
	logic [W-1:0]  fill_c;

	assign u     = universe_q;
	assign u_pad = UP'(u);
	assign adv   = !v_s6 || out_ch.ready;

	assign in_ch.ready        = adv;
	assign out_ch.valid       = v_s6;
	assign out_ch.next_subset = DATA_W'(res_s6);
	assign out_ch.is_last     = last_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			universe_q <= '1;
		end else if (cfg_we) begin
			universe_q <= cfg_wdata[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 2: positions above the lowest member that are free
	always_comb begin
		low_c  = s_s1 & (~s_s1 + W'(1));
		upto_c = (s_s1 != '0) ? (low_c | (low_c - W'(1))) : '0;
		cand_c = u & ~s_s1 & ~upto_c;
	end

	// stage 3: lowest candidate bit, kept members and the low part
	always_comb begin
		p_c    = cand_s2 & (~cand_s2 + W'(1));
		keep_c = s_s2 & ~(p_c | (p_c - W'(1)));
	end

	// stage 4: member count and per-byte universe ranks
	always_comb begin
		a_c = CW'($countones(m_s3));
		k_c = (!last_s3 && a_c != '0) ? (a_c - CW'(1)) : '0;
		for (int g = 0; g < NG; g++) begin
			grp_c     = u_pad[g*8 +: 8];
			gtot_c[g] = 4'($countones(grp_c));
			for (int j = 0; j < 8; j++) begin
				lrank_c[g*8+j] = 4'($countones(grp_c & 8'((1 << j) - 1)));
			end
		end
	end

	// stage 5: absolute rank of each universe position
	always_comb begin
		base_c = '0;
		for (int g = 0; g < NG; g++) begin
			for (int j = 0; j < 8; j++) begin
				if (g*8 + j < W) begin
					rank_c[g*8+j] = base_c + CW'(lrank_s4[g*8+j]);
				end
			end
			base_c = base_c + CW'(gtot_s4[g]);
		end
	end

	// stage 6: refill with the lowest universe bits
	always_comb begin
		for (int i = 0; i < W; i++) begin
			fill_c[i] = u[i] && (rank_s5[i] < k_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1    <= in_ch.current_subset[W-1:0] & u;
			s_s2    <= s_s1;
			cand_s2 <= cand_c;
			last_s3 <= (cand_s2 == '0);
			hit_s3  <= (cand_s2 == '0) ? s_s2 : (keep_c | p_c);
			m_s3    <= s_s2 & (p_c - W'(1));
			hit_s4  <= hit_s3;
			k_s4    <= k_c;
			last_s4 <= last_s3;
			lrank_s4 <= lrank_c;
			gtot_s4  <= gtot_c;
			hit_s5  <= hit_s4;
			k_s5    <= k_s4;
			last_s5 <= last_s4;
			rank_s5 <= rank_c;
			res_s6  <= hit_s5 | fill_c;
			last_s6 <= last_s5;
		end
	end

`ifndef SYNTH
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6}))
		else $error("pipeline valid bits moved during a stall");

	a_successor_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !last_s3 |-> hit_s3 != '0)
		else $error("successor lost its carry bit");

	a_no_bits_above_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.next_subset >> W) == '0)
		else $error("result holds bits above the set width");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for next_submask_same_popcount_core: random and corner subsets under several
// universe masks, successors checked against a scoreboard class with its own predictor
// depends on nsp_pkg, nsp_if and the core

module tb_top;
	import nsp_pkg::*;

	class successor_board;
		typedef struct packed {
			word_t next_subset;
			logic  is_last;
		} successor_t;

		word_t      universe;
		successor_t pending[$];
		int         errors;

		function new();
			universe = '1;
			errors = 0;
		endfunction

		function successor_t successor_of(word_t subset);
			word_t      s, low, upto_low, cand, p, keep, fill;
			int         a, taken;
			successor_t r;
			s = subset & universe;
			low = s & (~s + 64'd1);
			upto_low = (s != '0) ? (low | (low - 64'd1)) : '0;
			cand = universe & ~s & ~upto_low;
			if (cand == '0) begin
				r.next_subset = s;
				r.is_last = 1'b1;
				return r;
			end
			p = cand & (~cand + 64'd1);
			keep = s & ~(p | (p - 64'd1));
			a = $countones(s & (p - 64'd1));
			fill = '0;
			taken = 0;
			for (int i = 0; i < DATA_W; i++) begin
				if (universe[i] && taken < a - 1) begin
					fill[i] = 1'b1;
					taken++;
				end
			end
			r.next_subset = keep | p | fill;
			r.is_last = 1'b0;
			return r;
		endfunction

		function void note_subset(word_t subset);
			pending.push_back(successor_of(subset));
		endfunction

		task report(string what);
			if (errors < 40)
				$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_successor(word_t got_next, logic got_last);
			successor_t want;
			if (pending.size() == 0) begin
				report($sformatf("result %h with no transaction pending", got_next));
				return;
			end
			want = pending.pop_front();
			if (got_next !== want.next_subset)
				report($sformatf("next_subset %h, want %h", got_next, want.next_subset));
			if (got_last !== want.is_last)
				report($sformatf("is_last %b, want %b (next %h)", got_last, want.is_last,
					want.next_subset));
		endtask
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_we;
	word_t cfg_wdata;

	nsp_in_if  in_ch();
	nsp_out_if out_ch();

	next_submask_same_popcount_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	successor_board board;

	int burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_hold = 0;

	word_t corner_subsets[16] = '{
		64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
		64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
		64'h0000_0000_0000_0002, 64'h0000_0000_0000_0003,
		64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFE,
		64'h7FFF_FFFF_FFFF_FFFF, 64'hC000_0000_0000_0000,
		64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
		64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
		64'h4000_0000_0000_000F, 64'h0000_0000_0000_00F0
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		case (rx_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			2: out_ch.ready <= (rx_left % 4 == 0);
			default: begin
				if (rx_hold > 0) begin
					rx_hold--;
					out_ch.ready <= 1'b0;
				end else begin
					out_ch.ready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						rx_hold = $urandom_range(4, 16);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check_successor(out_ch.next_subset, out_ch.is_last);
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_subset(word_t v);
		in_ch.valid <= 1'b1;
		in_ch.current_subset <= v;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		board.note_subset(v);
		@(negedge clk);
	endtask

	task automatic offer_subset(word_t v);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(60, 150);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(0, 8);
			end
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push_subset(v);
	endtask

	function automatic word_t top_bits(word_t u, int k);
		word_t v;
		int    taken;
		v = '0;
		taken = 0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (u[i] && taken < k) begin
				v[i] = 1'b1;
				taken++;
			end
		end
		return v;
	endfunction

	function automatic word_t bottom_bits(word_t u, int k);
		word_t v;
		int    taken;
		v = '0;
		taken = 0;
		for (int i = 0; i < DATA_W; i++) begin
			if (u[i] && taken < k) begin
				v[i] = 1'b1;
				taken++;
			end
		end
		return v;
	endfunction

	function automatic word_t random_subset(word_t u);
		word_t r, v;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = r;
			1: v = r & u;
			2: v = r & {$urandom, $urandom} & {$urandom, $urandom} & u;
			3: v = (r | {$urandom, $urandom}) & u;
			4: v = top_bits(u, $urandom_range(0, $countones(u)));
			5: v = top_bits(u, $urandom_range(0, $countones(u)))
				^ (64'd1 << $urandom_range(0, DATA_W - 1));
			6: v = bottom_bits(u, $urandom_range(0, $countones(u)));
			default: v = r & u & ((64'd1 << $urandom_range(1, DATA_W - 1)) - 64'd1);
		endcase
		if ($urandom_range(0, 3) == 0)
			v |= {$urandom, $urandom} & ~u;
		return v;
	endfunction

	task automatic random_items(int n);
		repeat (n) offer_subset(random_subset(board.universe));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_universe(word_t u);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= u;
		board.universe = u;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		word_t ru;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.current_subset = '0;
		out_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset universe, all ones
		foreach (corner_subsets[i])
			offer_subset(corner_subsets[i]);
		random_items(260);

		set_universe('0);
		offer_subset('0);
		offer_subset('1);
		random_items(20);

		set_universe(64'h8000_0000_0000_0000);
		offer_subset('0);
		offer_subset(64'h8000_0000_0000_0000);
		offer_subset(64'h7FFF_FFFF_FFFF_FFFF);
		random_items(20);

		set_universe(64'h0000_0000_0000_0001);
		offer_subset('0);
		offer_subset(64'h0000_0000_0000_0001);
		random_items(15);

		set_universe(64'h8000_0000_0000_0001);
		offer_subset(64'h0000_0000_0000_0001);
		offer_subset(64'h8000_0000_0000_0000);
		offer_subset('1);
		random_items(20);

		set_universe(64'hAAAA_AAAA_AAAA_AAAA);
		random_items(260);

		ru = {$urandom, $urandom};
		set_universe(ru);
		random_items(260);

		ru = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
		set_universe(ru);
		random_items(260);

		set_universe(~ru);
		random_items(260);

		set_universe('1);
		random_items(350);

		drain();
		repeat (20) @(posedge clk);
		if (board.pending.size() != 0)
			board.report($sformatf("%0d results never arrived", board.pending.size()));
		if (board.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
